FILE: src/ipr_pkg.sv
package ipr_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_SCALE_DEF = 64;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int SCALE_W    = 7;
    localparam int SRC_W_W    = 11;
    localparam int SRC_H_W    = 13;
    localparam int ROW_W      = 12;
    localparam int WIDE_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       row_done;
        logic [1:0] pad_bytes;
        logic       frame_done;
        logic       run_last;
        logic       phase_error;
    } out_item_t;

    // one accepted item, as handed from the control stage to the emitter
    typedef struct packed {
        logic               err;
        logic               use_mem;
        logic               row_end;
        logic               frame_end;
        logic [1:0]         pad;
        logic [SCALE_W-1:0] count;
        logic [PIX_W-1:0]   pix;
    } job_t;

endpackage

FILE: src/ipr_line_store.sv
module ipr_line_store #(
    parameter int DEPTH = ipr_pkg::MAX_WIDTH_DEF,
    parameter int AW    = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [AW-1:0]            addr,
    input  logic [ipr_pkg::PIX_W-1:0] wr_data,
    output logic [ipr_pkg::PIX_W-1:0] rd_data
);

    logic [ipr_pkg::PIX_W-1:0] mem [DEPTH];
    logic [ipr_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

FILE: src/ipr_ctrl.sv
module ipr_ctrl #(
    parameter int MAX_WIDTH = ipr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = ipr_pkg::MAX_SCALE_DEF,
    parameter int AW        = 10,
    parameter int RW        = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ipr_pkg::in_item_t             in_data,
    input  logic [ipr_pkg::SCALE_W-1:0]   scale_cfg,
    input  logic [ipr_pkg::SRC_W_W-1:0]   width_cfg,
    input  logic [ipr_pkg::SRC_H_W-1:0]   height_cfg,
    input  logic                          a_move,
    output logic                          a_valid,
    output ipr_pkg::job_t                 a_job,
    output logic                          mem_wr,
    output logic                          mem_rd,
    output logic [AW-1:0]                 mem_addr,
    output logic [ipr_pkg::PIX_W-1:0]     mem_wdata
);

    localparam logic [ipr_pkg::SCALE_W-1:0] SCALE_CAP = ipr_pkg::SCALE_W'(MAX_SCALE);
    localparam logic [ipr_pkg::WIDE_W-1:0]  WIDTH_CAP = ipr_pkg::WIDE_W'(MAX_WIDTH);
    localparam logic [ipr_pkg::SRC_H_W-1:0] HEIGHT_CAP =
        ipr_pkg::SRC_H_W'(ipr_pkg::HEIGHT_LIMIT);

    logic [AW-1:0]               col_reg, col_next;
    logic [RW-1:0]               rep_reg, rep_next;
    logic [ipr_pkg::ROW_W-1:0]   row_reg, row_next;
    logic                        phase_reg, phase_next;
    logic                        a_valid_reg, a_valid_next;
    ipr_pkg::job_t               a_job_reg, a_job_next;

    logic [ipr_pkg::SCALE_W-1:0] s;
    logic [ipr_pkg::WIDE_W-1:0]  w;
    logic [ipr_pkg::WIDE_W-1:0]  width_ext;
    logic [ipr_pkg::SRC_H_W-1:0] h;
    logic                        in_xfer;
    logic                        err;
    logic                        end_col;
    logic                        last_rep;
    logic                        last_row;

    assign width_ext = ipr_pkg::WIDE_W'(width_cfg);

    always_comb
    begin
        if (scale_cfg == '0)
            s = ipr_pkg::SCALE_W'(1);
        else if (scale_cfg > SCALE_CAP)
            s = SCALE_CAP;
        else
            s = scale_cfg;

        if (width_ext == '0)
            w = ipr_pkg::WIDE_W'(1);
        else if (width_ext > WIDTH_CAP)
            w = WIDTH_CAP;
        else
            w = width_ext;

        if (height_cfg == '0)
            h = ipr_pkg::SRC_H_W'(1);
        else if (height_cfg > HEIGHT_CAP)
            h = HEIGHT_CAP;
        else
            h = height_cfg;
    end

    assign in_stall = a_valid_reg && !a_move;
    assign in_xfer  = in_valid && !in_stall;
    assign err      = in_data.mode != phase_reg;

    assign end_col  = (ipr_pkg::WIDE_W'(col_reg) + ipr_pkg::WIDE_W'(1)) >= w;
    assign last_rep = (ipr_pkg::SCALE_W'(rep_reg) + ipr_pkg::SCALE_W'(1)) >= s;
    assign last_row = (ipr_pkg::SRC_H_W'(row_reg) + ipr_pkg::SRC_H_W'(1)) >= h;

    // one item per cycle at most, so a read never meets a write to the same entry
    assign mem_addr  = col_reg;
    assign mem_wdata = {in_data.red_in, in_data.green_in, in_data.blue_in};
    assign mem_wr    = in_xfer && !err && !in_data.mode;
    assign mem_rd    = in_xfer && !err && in_data.mode;

    always_comb
    begin
        col_next     = col_reg;
        rep_next     = rep_reg;
        row_next     = row_reg;
        phase_next   = phase_reg;
        a_valid_next = a_valid_reg;
        a_job_next   = a_job_reg;

        if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        if (in_xfer)
        begin
            a_valid_next = 1'b1;
            if (err)
            begin
                a_job_next       = '0;
                a_job_next.err   = 1'b1;
                a_job_next.count = ipr_pkg::SCALE_W'(1);
            end
            else
            begin
                a_job_next.err       = 1'b0;
                a_job_next.use_mem   = in_data.mode;
                a_job_next.row_end   = end_col && last_rep;
                a_job_next.frame_end = end_col && last_rep && last_row;
                a_job_next.pad       = 2'(w[1:0] * s[1:0]);
                a_job_next.count     = s;
                a_job_next.pix       = mem_wdata;

                if (end_col)
                begin
                    col_next = '0;
                    if (last_rep)
                    begin
                        rep_next   = '0;
                        phase_next = 1'b0;
                        row_next   = last_row ? '0 : row_reg + ipr_pkg::ROW_W'(1);
                    end
                    else
                    begin
                        rep_next   = rep_reg + RW'(1);
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            rep_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            rep_reg     <= rep_next;
            row_reg     <= row_next;
            phase_reg   <= phase_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_job_reg <= a_job_next;
    end

    assign a_valid = a_valid_reg;
    assign a_job   = a_job_reg;

endmodule

FILE: src/ipr_emit.sv
module ipr_emit #(
    parameter int MAX_SCALE = ipr_pkg::MAX_SCALE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      a_valid,
    input  ipr_pkg::job_t             a_job,
    input  logic [ipr_pkg::PIX_W-1:0] rd_data,
    output logic                      a_move,
    output logic                      out_valid,
    input  logic                      out_stall,
    output ipr_pkg::out_item_t        out_data
);

    logic                        e_valid_reg, e_valid_next;
    ipr_pkg::job_t               e_job_reg, e_job_next;
    logic [ipr_pkg::SCALE_W-1:0] cnt_reg, cnt_next;
    logic                        last;
    logic                        e_take;

    assign last   = cnt_reg == '0;
    assign e_take = !e_valid_reg || (last && !out_stall);
    assign a_move = a_valid && e_take;

    always_comb
    begin
        e_valid_next = e_valid_reg;
        e_job_next   = e_job_reg;
        cnt_next     = cnt_reg;

        if (e_take)
        begin
            e_valid_next = a_valid;
            if (a_valid)
            begin
                e_job_next = a_job;
                // stored pixel arrives from the line store in the cycle after the read
                if (a_job.use_mem)
                begin
                    e_job_next.pix = rd_data;
                end
                cnt_next = a_job.count - ipr_pkg::SCALE_W'(1);
            end
        end
        else if (!out_stall)
        begin
            cnt_next = cnt_reg - ipr_pkg::SCALE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_job_reg <= e_job_next;
    end

    assign out_valid            = e_valid_reg;
    assign out_data.blue_out    = e_job_reg.pix[7:0];
    assign out_data.green_out   = e_job_reg.pix[15:8];
    assign out_data.red_out     = e_job_reg.pix[23:16];
    assign out_data.row_done    = last && e_job_reg.row_end;
    assign out_data.pad_bytes   = (last && e_job_reg.row_end) ? e_job_reg.pad : 2'b00;
    assign out_data.frame_done  = last && e_job_reg.frame_end;
    assign out_data.run_last    = last;
    assign out_data.phase_error = e_job_reg.err;

    assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> cnt_reg < ipr_pkg::SCALE_W'(MAX_SCALE))
        else $error("copy count beyond scale limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg && e_job_reg.err |-> last)
        else $error("phase error transfer is not a single result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_done |-> out_data.row_done && out_data.run_last)
        else $error("frame end without row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg && !out_stall && !last |=>
            e_valid_reg && cnt_reg == $past(cnt_reg) - ipr_pkg::SCALE_W'(1))
        else $error("copy run broken before its last transfer");

endmodule

FILE: src/integer_pixel_replicate_scaler.sv
// path: an item is registered in the control stage, then in the emitter, before its first copy can transfer
// output: scale_factor copies per item (1 for a phase error), the emitter
// sends one copy per cycle while out_stall is low; one item waits in the control stage meanwhile
// reset (rst_n, async, active low) clears the row, repeat and column counters,
// the phase and all valid flags; registers return to 1; the line store is not cleared
module integer_pixel_replicate_scaler #(
    parameter int MAX_WIDTH = ipr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = ipr_pkg::MAX_SCALE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ipr_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ipr_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ipr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    logic [ipr_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [ipr_pkg::SRC_W_W-1:0] width_reg, width_next;
    logic [ipr_pkg::SRC_H_W-1:0] height_reg, height_next;

    logic                      a_valid;
    ipr_pkg::job_t             a_job;
    logic                      a_move;
    logic                      mem_wr;
    logic                      mem_rd;
    logic [AW-1:0]             mem_addr;
    logic [ipr_pkg::PIX_W-1:0] mem_wdata;
    logic [ipr_pkg::PIX_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        scale_next  = scale_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ipr_pkg::REG_SCALE:  scale_next  = cfg_data[ipr_pkg::SCALE_W-1:0];
                ipr_pkg::REG_WIDTH:  width_next  = cfg_data[ipr_pkg::SRC_W_W-1:0];
                ipr_pkg::REG_HEIGHT: height_next = cfg_data[ipr_pkg::SRC_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= ipr_pkg::SCALE_W'(1);
            width_reg  <= ipr_pkg::SRC_W_W'(1);
            height_reg <= ipr_pkg::SRC_H_W'(1);
        end
        else
        begin
            scale_reg  <= scale_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    ipr_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE),
        .AW        (AW),
        .RW        (RW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .scale_cfg  (scale_reg),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .a_move     (a_move),
        .a_valid    (a_valid),
        .a_job      (a_job),
        .mem_wr     (mem_wr),
        .mem_rd     (mem_rd),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata)
    );

    ipr_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (mem_wr),
        .rd_en   (mem_rd),
        .addr    (mem_addr),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata)
    );

    ipr_emit #(
        .MAX_SCALE (MAX_SCALE)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_valid   (a_valid),
        .a_job     (a_job),
        .rd_data   (mem_rdata),
        .a_move    (a_move),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
